// ----- rtl/core/dtcf_pkg.sv -----
// package: payload types and constants for the double to compressed float converter
package dtcf_pkg;

    typedef struct packed {
        logic [63:0] value_bits;
        logic [3:0]  mantissa_bytes;
    } t_in_word;

    typedef struct packed {
        logic signed [7:0] exp_out;
        logic [63:0]       mant_out;
        logic              range_flag;
    } t_out_word;

    // normalized operand handed from the front stage to the rounding stage
    typedef struct packed {
        logic        special;   // infinity or nan
        logic        zero;
        logic        neg;
        logic [52:0] m;         // significand with leading one at bit 52
        logic [11:0] e;         // signed exponent, value = m * 2^(e-53)
        logic [2:0]  nb_m1;     // clamped byte count minus one
    } t_norm;

endpackage

// ----- rtl/core/dtcf_norm.sv -----
// module: field split, byte count clamp and subnormal normalization
module dtcf_norm (
    input  dtcf_pkg::t_in_word i_word,
    output dtcf_pkg::t_norm    o_norm
);

    logic [10:0] bexp;
    logic [51:0] frac;
    logic [5:0]  lz;
    logic        found;

    assign bexp = i_word.value_bits[62:52];
    assign frac = i_word.value_bits[51:0];

    // leading zero count of the fraction, top bit first
    always_comb begin
        lz    = 6'd0;
        found = 1'b0;
        for (int i = 51; i >= 0; i--) begin
            if (!found && frac[i]) begin
                lz    = 6'(51 - i);
                found = 1'b1;
            end
        end
    end

    always_comb begin
        o_norm.special = (bexp == 11'h7FF);
        o_norm.zero    = (bexp == 11'd0) && (frac == 52'd0);
        o_norm.neg     = i_word.value_bits[63];
        if (i_word.mantissa_bytes == 4'd0) begin
            o_norm.nb_m1 = 3'd0;
        end else if (i_word.mantissa_bytes > 4'd8) begin
            o_norm.nb_m1 = 3'd7;
        end else begin
            o_norm.nb_m1 = 3'(i_word.mantissa_bytes - 4'd1);
        end
        if (bexp != 11'd0) begin
            o_norm.m = {1'b1, frac};
            o_norm.e = 12'({1'b0, bexp}) - 12'd1022;
        end else begin
            o_norm.m = 53'({1'b0, frac} << (lz + 6'd1));
            o_norm.e = 12'(-12'sd1022) - 12'({6'd0, lz});
        end
    end

endmodule

// ----- rtl/core/dtcf_round.sv -----
// module: exponent bias, rounding shift and sign insertion
module dtcf_round (
    input  dtcf_pkg::t_norm     i_norm,
    output dtcf_pkg::t_out_word o_word
);

    logic [6:0]  shift;
    logic [12:0] x;
    logic [63:0] m64;
    logic [63:0] mag;
    logic [5:0]  r;
    logic [63:0] sum;

    always_comb begin
        shift = 7'({i_norm.nb_m1, 3'b000}) + 7'd6;
        x     = 13'({i_norm.e[11], i_norm.e}) - 13'({6'd0, shift});
        m64   = {11'd0, i_norm.m};
        r     = 6'd0;
        sum   = 64'd0;
        if (shift >= 7'd53) begin
            mag = m64 << (shift - 7'd53);
        end else begin
            r   = 6'(7'd53 - shift);
            sum = m64 + (64'd1 << (r - 6'd1));
            mag = sum >> r;
        end
        if (i_norm.neg) begin
            mag[{i_norm.nb_m1, 3'b111}] = 1'b1;
        end
        o_word.exp_out    = x[7:0];
        o_word.mant_out   = mag;
        o_word.range_flag = 1'b0;
        if (i_norm.special) begin
            o_word.exp_out    = 8'd0;
            o_word.mant_out   = 64'd0;
            o_word.range_flag = 1'b1;
        end else if (i_norm.zero) begin
            o_word.exp_out  = 8'(-{1'b0, shift});
            o_word.mant_out = 64'd0;
        end else if ($signed(x) <= -13'sd128) begin
            o_word.exp_out  = 8'd0;
            o_word.mant_out = 64'd0;
        end else if ($signed(x) > 13'sd127) begin
            o_word.range_flag = 1'b1;
        end
    end

endmodule

// ----- rtl/core/double_to_compressed_float_top.sv -----
// top level: double to compressed float converter with three register stages
//
// channel  dir  handshake          word
// in       in   i_valid / o_ready  dtcf_pkg::t_in_word
// out      out  o_valid / i_ready  dtcf_pkg::t_out_word
//
// one word per cycle sustained while i_ready holds; data passes the input, mid and result registers in turn
// normalization sits before the mid register, rounding shift after it
// synchronous active-low reset clears the valid bits only
// a stall at the output holds each stage that is full and whose successor is full
module double_to_compressed_float_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  dtcf_pkg::t_in_word  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output dtcf_pkg::t_out_word o_data
);

    logic                r_in_valid;
    dtcf_pkg::t_in_word  r_in;
    logic                r_mid_valid;
    dtcf_pkg::t_norm     r_mid;
    logic                r_out_valid;
    dtcf_pkg::t_out_word r_out;

    dtcf_pkg::t_norm     n_mid;
    dtcf_pkg::t_out_word n_out;
    logic                out_move;
    logic                mid_move;
    logic                in_move;

    // stage advance, each stage moves when it is empty or the next one drains
    assign out_move = !r_out_valid || i_ready;
    assign mid_move = !r_mid_valid || out_move;
    assign in_move  = !r_in_valid  || mid_move;
    assign o_ready  = in_move;

    dtcf_norm u_norm (
        .i_word (r_in),
        .o_norm (n_mid)
    );

    dtcf_round u_round (
        .i_norm (r_mid),
        .o_word (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_mid_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_move)  r_in_valid  <= i_valid;
            if (mid_move) r_mid_valid <= r_in_valid;
            if (out_move) r_out_valid <= r_mid_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_move && i_valid)      r_in  <= i_data;
        if (mid_move && r_in_valid)  r_mid <= n_mid;
        if (out_move && r_mid_valid) r_out <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
